// ===== rtl/iwr_pkg.sv =====
// ---------------------------------------------------------------------------
// Instruction window retire package
// Opcodes, configuration register indexes, reset values and the status
// record shared by the instruction window logic.
// ---------------------------------------------------------------------------
package iwr_pkg;

	// Request opcodes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_RETIRE = 2'd1;
	localparam logic [1:0] OP_WAKEUP = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_RETIRE_WIDTH = 2'd0;
	localparam logic [1:0] CFG_LINE_OFFSET  = 2'd1;

	// Configuration reset values and the retire ceiling.
	localparam logic [3:0] RETIRE_WIDTH_RST = 4'd4;
	localparam logic [3:0] LINE_OFFSET_RST  = 4'd6;
	localparam logic [3:0] RETIRE_MAX       = 4'd8;

	// Status fields of one result, apart from the occupancy.
	typedef struct packed {
		logic [3:0] retired_count;
		logic       ring_full;
		logic       ring_empty;
		logic       rejected;
	} iwr_status_t;

endpackage

// ===== rtl/instruction_window_retire.sv =====
// ---------------------------------------------------------------------------
// Instruction window retire
// Ring of DEPTH entries with a ready bit and an address each, supporting
// insert at the head, in-order retire from the tail and wakeup by address.
// ---------------------------------------------------------------------------
// The block handles one request at a time and returns one status result per
// request. A retire tick examines entries from the tail (at most RETIRE_MAX)
// and a wakeup examines every occupied entry, through the single read port
// of each entry memory, which steps through the ring one entry per cycle.
// A new request is accepted while the previous result still waits in the
// output register; a result held back by out_stall delays only the
// completion of the following request.
module instruction_window_retire
	import iwr_pkg::*;
#(
	parameter int DEPTH     = 128,
	parameter int ADDR_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     opcode,
	input  logic                           entry_ready,
	input  logic [ADDR_BITS-1:0]           address,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     retired_count,
	output logic [$clog2(DEPTH+1)-1:0]     occupancy,
	output logic                           is_full_flag,
	output logic                           is_empty_flag,
	output logic                           insert_rejected,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [3:0]                     cfg_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_RET  = 3'd2;
	localparam logic [2:0] ST_WAKE = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [2:0]           st_q;
	logic [3:0]           retire_width_q;
	logic [3:0]           line_offset_q;
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [3:0]           ret_q;
	logic                 rej_q;
	logic [PTR_W-1:0]     walk_idx_q;
	logic [CNT_W-1:0]     walk_left_q;
	logic                 out_valid_q;

	// Latched request.
	logic [1:0]           op_q;
	logic                 rdy_q;
	logic [ADDR_BITS-1:0] addr_q;

	// Wakeup compare stage.
	logic                 vld_s1;
	logic [PTR_W-1:0]     idx_s1;

	// Entry memories and their registered read data.
	logic                 rdy_mem [DEPTH];
	logic [ADDR_BITS-1:0] adr_mem [DEPTH];
	logic                 rdy_rd_s1;
	logic [ADDR_BITS-1:0] adr_rd_s1;

	// Result register.
	iwr_status_t          res_q;
	logic [CNT_W-1:0]     occ_q;

	logic [3:0]           limit;
	logic [PTR_W-1:0]     tail_nx;
	logic                 ret_go;
	logic                 ret_more;
	logic                 rdy_re;
	logic [PTR_W-1:0]     rdy_ridx;
	logic                 ins_ok;
	logic [ADDR_BITS-1:0] keep;
	logic                 wake_hit;
	logic                 rdy_we;
	logic [PTR_W-1:0]     rdy_widx;
	logic                 rdy_wdata;
	logic                 adr_re;
	logic                 res_load;

	// Datapath control for the memories.
	always_comb begin
		limit    = (retire_width_q > RETIRE_MAX) ? RETIRE_MAX : retire_width_q;
		tail_nx  = ring_next(tail_q);
		ret_go   = (st_q == ST_RET) && rdy_rd_s1;
		ret_more = ret_go && (cnt_q > CNT_W'(1)) && ((ret_q + 4'd1) < limit);
		rdy_re   = ((st_q == ST_EXEC) && (op_q == OP_RETIRE) && (cnt_q != '0)
			&& (limit != '0)) || ret_more;
		rdy_ridx = (st_q == ST_EXEC) ? tail_q : tail_nx;
		ins_ok   = (st_q == ST_EXEC) && (op_q == OP_INSERT)
			&& (cnt_q != CNT_W'(DEPTH));
		keep     = {ADDR_BITS{1'b1}} << line_offset_q;
		wake_hit = vld_s1 && ((adr_rd_s1 & keep) == (addr_q & keep));
		rdy_we   = ins_ok || wake_hit;
		rdy_widx = ins_ok ? head_q : idx_s1;
		rdy_wdata = ins_ok ? rdy_q : 1'b1;
		adr_re   = (st_q == ST_WAKE) && (walk_left_q != '0);
		res_load = (st_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// Ready bit memory: one write port, one read port.
	always_ff @(posedge clk) begin
		if (rdy_we) begin
			rdy_mem[rdy_widx] <= rdy_wdata;
		end
		if (rdy_re) begin
			rdy_rd_s1 <= rdy_mem[rdy_ridx];
		end
	end

	// Address memory: written on insert, read while a wakeup walks the ring.
	always_ff @(posedge clk) begin
		if (ins_ok) begin
			adr_mem[head_q] <= addr_q;
		end
		if (adr_re) begin
			adr_rd_s1 <= adr_mem[walk_idx_q];
		end
	end

	// Configuration registers; writes are always taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retire_width_q <= RETIRE_WIDTH_RST;
			line_offset_q  <= LINE_OFFSET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RETIRE_WIDTH: retire_width_q <= cfg_data;
				CFG_LINE_OFFSET:  line_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request latch, taken when the sequencer is idle.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			op_q   <= opcode;
			rdy_q  <= entry_ready;
			addr_q <= address;
		end
		idx_s1 <= walk_idx_q;
	end

	// Sequencer and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			ret_q       <= '0;
			rej_q       <= 1'b0;
			walk_idx_q  <= '0;
			walk_left_q <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= adr_re;
			// A loaded result raises valid; a taken one drops it.
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ret_q <= '0;
					rej_q <= (op_q == OP_INSERT) && !ins_ok;
					unique case (op_q)
						OP_INSERT: begin
							if (ins_ok) begin
								head_q <= ring_next(head_q);
								cnt_q  <= cnt_q + 1'b1;
							end
							st_q <= ST_DONE;
						end
						OP_RETIRE: begin
							st_q <= rdy_re ? ST_RET : ST_DONE;
						end
						OP_WAKEUP: begin
							walk_idx_q  <= tail_q;
							walk_left_q <= cnt_q;
							st_q        <= (cnt_q != '0) ? ST_WAKE : ST_DONE;
						end
						default: begin
							st_q <= ST_DONE;
						end
					endcase
				end
				ST_RET: begin
					// Retire the examined entry if ready; read the next one if allowed.
					if (ret_go) begin
						tail_q <= tail_nx;
						cnt_q  <= cnt_q - 1'b1;
						ret_q  <= ret_q + 4'd1;
					end
					if (!ret_more) begin
						st_q <= ST_DONE;
					end
				end
				ST_WAKE: begin
					// Issue one address read per cycle; compare it in the next cycle.
					if (adr_re) begin
						walk_idx_q  <= ring_next(walk_idx_q);
						walk_left_q <= walk_left_q - 1'b1;
					end else if (!vld_s1) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.retired_count <= ret_q;
			res_q.ring_full     <= (cnt_q == CNT_W'(DEPTH));
			res_q.ring_empty    <= (cnt_q == '0);
			res_q.rejected      <= rej_q;
			occ_q               <= cnt_q;
		end
	end

	assign in_stall        = (st_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign retired_count   = res_q.retired_count;
	assign occupancy       = occ_q;
	assign is_full_flag    = res_q.ring_full;
	assign is_empty_flag   = res_q.ring_empty;
	assign insert_rejected = res_q.rejected;
	assign cfg_ready       = 1'b1;

	// The occupancy never exceeds the ring depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above window depth");

	// An empty ring has its head and tail together.
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (head_q == tail_q))
		else $error("head and tail differ on empty window");

	// A retire tick never removes more than the ceiling.
	a_ret_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (retired_count <= RETIRE_MAX))
		else $error("retired count above ceiling");

	// A dropped insert is only reported for a full window.
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && insert_rejected) |-> is_full_flag)
		else $error("insert rejected while window not full");

endmodule

// ===== tb/iwr_status_checker.sv =====
// ---------------------------------------------------------------------------
// Instruction window status checker
// Watches the request, result and configuration channels of the instruction
// window, keeps its own copy of the ring, predicts the status of each
// accepted request and compares it with the results in arrival order.
// ---------------------------------------------------------------------------
module iwr_status_checker
	import iwr_pkg::*;
#(
	parameter int DEPTH     = 128,
	parameter int ADDR_BITS = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic                       entry_ready,
	input  logic [ADDR_BITS-1:0]       address,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [3:0]                 retired_count,
	input  logic [$clog2(DEPTH+1)-1:0] occupancy,
	input  logic                       is_full_flag,
	input  logic                       is_empty_flag,
	input  logic                       insert_rejected,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [3:0]                 cfg_data,
	output int unsigned                failures,
	output int unsigned                outstanding,
	output int unsigned                rejects,
	output int unsigned                peak_held
);

	localparam int OCC_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [3:0]       retired;
		logic [OCC_W-1:0] held;
		logic             full;
		logic             empty;
		logic             rejected;
	} window_status_t;

	// Shadow copy of the window and its configuration.
	logic                 slot_ready [DEPTH];
	logic [ADDR_BITS-1:0] slot_addr  [DEPTH];
	int unsigned          head_slot;
	int unsigned          tail_slot;
	int unsigned          held_count;
	logic [3:0]           retire_width;
	logic [3:0]           line_offset;

	// Statuses still owed by the block, oldest first.
	window_status_t       status_due [$];
	int unsigned          bad_count;
	int unsigned          reject_count;
	int unsigned          peak_count;

	// Applies one request to the shadow window and returns its status.
	function automatic window_status_t advance_window(input logic [1:0] op, input logic rdy,
			input logic [ADDR_BITS-1:0] addr);
		window_status_t       st;
		int unsigned          limit;
		int unsigned          taken;
		int unsigned          idx;
		int unsigned          i;
		logic [ADDR_BITS-1:0] keep;
		st = '0;
		taken = 0;
		case (op)
		OP_INSERT: begin
			if (held_count >= DEPTH) begin
				st.rejected = 1'b1;
			end else begin
				slot_ready[head_slot] = rdy;
				slot_addr[head_slot] = addr;
				head_slot = (head_slot + 1) % DEPTH;
				held_count++;
			end
		end
		OP_RETIRE: begin
			// Retire in order, stopping at the width or at the first entry not ready.
			limit = (retire_width > RETIRE_MAX) ? RETIRE_MAX : retire_width;
			while (held_count > 0 && taken < limit && slot_ready[tail_slot]) begin
				tail_slot = (tail_slot + 1) % DEPTH;
				held_count--;
				taken++;
			end
		end
		OP_WAKEUP: begin
			// Every occupied entry in the same line becomes ready.
			keep = {ADDR_BITS{1'b1}} << line_offset;
			for (i = 0; i < held_count; i++) begin
				idx = (tail_slot + i) % DEPTH;
				if ((slot_addr[idx] & keep) == (addr & keep)) begin
					slot_ready[idx] = 1'b1;
				end
			end
		end
		default: begin
		end
		endcase
		st.retired = taken[3:0];
		st.held = held_count[OCC_W-1:0];
		st.full = (held_count == DEPTH);
		st.empty = (held_count == 0);
		return st;
	endfunction

	// Results are checked before new requests are predicted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		window_status_t want;
		window_status_t seen;
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			held_count = 0;
			retire_width = RETIRE_WIDTH_RST;
			line_offset = LINE_OFFSET_RST;
			status_due.delete();
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{retired_count, occupancy, is_full_flag, is_empty_flag, insert_rejected};
				if (status_due.size() == 0) begin
					bad_count++;
					if (bad_count <= 10) begin
						$display("unexpected result: retired %0d occupancy %0d full %b empty %b rejected %b",
							seen.retired, seen.held, seen.full, seen.empty, seen.rejected);
					end
				end else begin
					want = status_due.pop_front();
					if (seen !== want) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("status mismatch (expected/actual): retired %0d/%0d occupancy %0d/%0d %s",
								want.retired, seen.retired, want.held, seen.held,
								$sformatf("full %b/%b empty %b/%b rejected %b/%b",
									want.full, seen.full, want.empty, seen.empty,
									want.rejected, seen.rejected));
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = advance_window(opcode, entry_ready, address);
				status_due.push_back(want);
				if (want.rejected) begin
					reject_count++;
				end
				if (want.held > peak_count) begin
					peak_count = want.held;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_RETIRE_WIDTH: begin
					retire_width = cfg_data;
				end
				CFG_LINE_OFFSET: begin
					line_offset = cfg_data;
				end
				default: begin
				end
				endcase
			end
			failures <= bad_count;
			outstanding <= status_due.size();
			rejects <= reject_count;
			peak_held <= peak_count;
		end
	end

endmodule

// ===== tb/instruction_window_retire_tb.sv =====
// ---------------------------------------------------------------------------
// Instruction window retire testbench
// Drives directed and random insert, retire and wakeup requests through a
// series of register settings, with random idling on both channels, while
// the status checker predicts and compares every result.
// ---------------------------------------------------------------------------
module instruction_window_retire_tb;
	import iwr_pkg::*;

	localparam int DEPTH         = 128;
	localparam int ADDR_BITS     = 48;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = DEPTH + 16;
	localparam int POOL_SIZE     = 6;

	// Opcode and register indexes that the block does not use.
	localparam logic [1:0] OP_SPARE     = 2'd3;
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 opcode;
	logic                       entry_ready;
	logic [ADDR_BITS-1:0]       address;
	logic                       out_valid;
	logic                       out_stall;
	logic [3:0]                 retired_count;
	logic [$clog2(DEPTH+1)-1:0] occupancy;
	logic                       is_full_flag;
	logic                       is_empty_flag;
	logic                       insert_rejected;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index;
	logic [3:0]                 cfg_data;

	int unsigned                failures;
	int unsigned                outstanding;
	int unsigned                rejects;
	int unsigned                peak_held;
	int unsigned                cycle_count;
	int unsigned                sent_by_op [4];
	int unsigned                settings_used;
	bit                         quiet_mode;
	logic [ADDR_BITS-1:0]       line_pool [POOL_SIZE];
	logic [ADDR_BITS-1:0]       unready_lines [$];

	instruction_window_retire #(
		.DEPTH    (DEPTH),
		.ADDR_BITS(ADDR_BITS)
	) dut (.*);

	iwr_status_checker #(
		.DEPTH    (DEPTH),
		.ADDR_BITS(ADDR_BITS)
	) status_checker (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped by the watchdog after %0d cycles", cycle_count);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side stalls in random bursts.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_mode && arst_n && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [ADDR_BITS-1:0] random_address();
		return ADDR_BITS'({$urandom, $urandom});
	endfunction

	// Address near one of a few shared lines, so that wakeups find matches.
	function automatic logic [ADDR_BITS-1:0] line_address();
		logic [ADDR_BITS-1:0] low_mask;
		if ($urandom_range(0, 99) < 15) begin
			return random_address();
		end
		low_mask = ({{(ADDR_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, 14)) - 1'b1;
		return line_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (random_address() & low_mask);
	endfunction

	// Presents one request, with an optional idle burst first, and waits for it.
	task automatic send_request(input logic [1:0] op, input logic rdy,
			input logic [ADDR_BITS-1:0] addr);
		if (!quiet_mode && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		entry_ready <= rdy;
		address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_by_op[op]++;
	endtask

	// Builds one random request; insert_pct sets the share of inserts.
	task automatic send_random_request(input int unsigned insert_pct);
		int unsigned          roll;
		int unsigned          pick;
		logic                 rdy;
		logic [ADDR_BITS-1:0] addr;
		logic [1:0]           op;
		roll = $urandom_range(0, 99);
		rdy = ($urandom_range(0, 9) < 6);
		addr = random_address();
		if (roll < insert_pct) begin
			op = OP_INSERT;
			addr = line_address();
			if (!rdy) begin
				unready_lines.push_back(addr);
				if (unready_lines.size() > 64) begin
					void'(unready_lines.pop_front());
				end
			end
		end else if (roll >= 96) begin
			op = OP_SPARE;
		end else if ((roll - insert_pct) * 5 < (96 - insert_pct) * 2) begin
			op = OP_WAKEUP;
			// Mostly wake the oldest entries still waiting, sometimes off by low bits.
			if ($urandom_range(0, 9) < 6 && unready_lines.size() > 0) begin
				pick = $urandom_range(0, (unready_lines.size() > 4) ? 3 : unready_lines.size() - 1);
				addr = unready_lines[pick];
				unready_lines.delete(pick);
				if ($urandom_range(0, 1) == 1) begin
					addr[5:0] = 6'($urandom_range(0, 63));
				end
			end else if ($urandom_range(0, 2) > 0) begin
				addr = line_address();
			end
		end else begin
			op = OP_RETIRE;
		end
		send_request(op, rdy, addr);
	endtask

	// Writes one configuration register; valid stays up for a following write.
	task automatic write_register(input logic [1:0] idx, input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Stops requests and waits until every result has come back.
	task automatic drain_window();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// One register setting followed by a stretch of random requests.
	task automatic run_phase(input logic [3:0] width, input logic [3:0] offset,
			input int unsigned items, input int unsigned insert_pct, input bit quiet);
		drain_window();
		write_register(CFG_RETIRE_WIDTH, width);
		write_register(CFG_LINE_OFFSET, offset);
		cfg_valid <= 1'b0;
		quiet_mode <= quiet;
		settings_used++;
		repeat (items) send_random_request(insert_pct);
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_INSERT;
		entry_ready <= 1'b0;
		address <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_RETIRE_WIDTH;
		cfg_data <= '0;
		quiet_mode <= 1'b0;
		settings_used = 1;
		foreach (line_pool[i]) begin
			line_pool[i] = random_address();
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings: empty window cases first.
		send_request(OP_RETIRE, 1'b1, '1);
		send_request(OP_WAKEUP, 1'b0, '0);
		send_request(OP_SPARE, 1'b0, '0);
		// A not-ready entry at the tail blocks retirement until it is woken.
		send_request(OP_INSERT, 1'b0, '0);
		send_request(OP_INSERT, 1'b1, '1);
		send_request(OP_INSERT, 1'b1, 48'hAAAA_AAAA_AAAA);
		send_request(OP_INSERT, 1'b0, 48'h5555_5555_5555);
		send_request(OP_RETIRE, 1'b0, '0);
		send_request(OP_WAKEUP, 1'b1, 48'h0000_0000_003F);
		send_request(OP_RETIRE, 1'b1, '0);
		send_request(OP_WAKEUP, 1'b0, 48'h5555_5555_5540);
		send_request(OP_SPARE, 1'b1, '1);
		// More ready entries than the retire width allows in one tick.
		for (int i = 0; i < 5; i++) begin
			send_request(OP_INSERT, 1'b1, 48'h0000_0000_1000 + i);
		end
		send_request(OP_RETIRE, 1'b0, '1);
		send_request(OP_RETIRE, 1'b0, '0);
		send_request(OP_RETIRE, 1'b1, '0);
		send_request(OP_WAKEUP, 1'b1, '1);

		// Writes to unused register indexes must change nothing.
		drain_window();
		write_register(CFG_SPARE_LO, 4'($urandom_range(0, 15)));
		write_register(CFG_SPARE_HI, 4'($urandom_range(0, 15)));
		cfg_valid <= 1'b0;

		// Random part; the zero width phase fills the window past full.
		run_phase(4'd8, 4'd0, 100, 50, 1'b0);
		run_phase(4'd1, 4'd12, 100, 45, 1'b0);
		run_phase(4'd0, 4'd15, 160, 90, 1'b0);
		run_phase(4'd15, 4'd3, 120, 25, 1'b0);
		run_phase(4'd2, 4'd9, 100, 45, 1'b1);
		run_phase(4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)), 100, 45, 1'b0);
		run_phase(4'd3, 4'd12, 100, 50, 1'b0);
		run_phase(4'd7, 4'd6, 120, 45, 1'b1);

		drain_window();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d inserts, %0d retire ticks, %0d wakeups and %0d unused opcodes.",
			sent_by_op[OP_INSERT], sent_by_op[OP_RETIRE], sent_by_op[OP_WAKEUP],
			sent_by_op[OP_SPARE]);
		$display("Used %0d register settings; peak occupancy %0d of %0d, %0d inserts dropped.",
			settings_used, peak_held, DEPTH, rejects);
		if (failures == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
